FILE: rtl/core/bale_pkg.sv
`default_nettype none

package bale_pkg;

  // List geometry.
  localparam int CAPACITY = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int WORD_W   = 32;
  localparam int POS_W    = 6;
  localparam int CMD_W    = 3;
  localparam int STAT_W   = 3;

  // Stream word widths, rounded up to whole bytes.
  localparam int IN_TDATA_W  = ((WORD_W + POS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((WORD_W + CNT_W + 1 + 7) / 8) * 8;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RMODD  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MIN    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_BEYOND   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_UNFILLED = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd4;

  typedef logic signed [WORD_W-1:0] word_t;

  // One result word as it leaves the core.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    word_t             data;
    logic [CNT_W-1:0]  count;
    logic              is_full;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/bounded_array_list_engine.sv
`default_nettype none

// Bounded array list engine. Keeps a list of up to 32 signed 32-bit words in
// a single-port-write, registered-read memory plus a fill count. Each input
// word carries a command on in_tuser (append, sorted insert, remove odd
// entries, minimum, read position, clear) and returns exactly one output
// word with the status on out_tuser and the data, count and full flag on
// out_tdata. One item is processed at a time. Sorted insert, remove-odd and
// minimum walk the memory one entry per cycle through its single read port,
// and a read waits for the registered memory word before its result is
// set. The next item is accepted in the cycle after the result moves on.
// The output register lets the next item be accepted while a finished
// result waits to be taken.
module bounded_array_list_engine (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // value [31:0], position [37:32], zero fill above
  input  wire logic [bale_pkg::IN_TDATA_W-1:0]     in_tdata,
  // cmd [2:0]
  input  wire logic [bale_pkg::CMD_W-1:0]          in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // data [31:0], count [37:32], is_full [38], zero fill above
  output logic [bale_pkg::OUT_TDATA_W-1:0]         out_tdata,
  // status [2:0]
  output logic [bale_pkg::STAT_W-1:0]              out_tuser
);
  import bale_pkg::*;

  word_t            in_value;
  logic [POS_W-1:0] in_position;
  logic             res_valid;
  logic             res_ready;
  result_t          res;

  // Unpack the input word.
  assign in_value    = word_t'(in_tdata[WORD_W-1:0]);
  assign in_position = in_tdata[WORD_W +: POS_W];

  bale_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_cmd      (in_tuser),
    .in_value    (in_value),
    .in_position (in_position),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  bale_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

FILE: rtl/core/bale_core.sv
`default_nettype none

module bale_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [bale_pkg::CMD_W-1:0]    in_cmd,
  input  wire bale_pkg::word_t               in_value,
  input  wire logic [bale_pkg::POS_W-1:0]    in_position,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output bale_pkg::result_t                  res
);
  import bale_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_RDWAIT = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  word_t             val_r, val_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [ADDR_W-1:0] pidx_r, pidx_nxt;
  logic              pend_r, pend_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  word_t             acc_r, acc_nxt;
  logic              found_r, found_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  word_t             data_r, data_nxt;

  // Entry memory with one write port and one registered read port.
  word_t             mem [CAPACITY];
  word_t             rdata_r;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  word_t             wdata;
  logic [ADDR_W-1:0] raddr;
  logic              rd_issue;
  logic              full;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign full      = (cnt_r == CNT_W'(CAPACITY));
  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  assign res.status  = status_r;
  assign res.data    = data_r;
  assign res.count   = cnt_r;
  assign res.is_full = full;

  // Sequencer: commands that need no memory read finish at once; a read waits
  // for the registered read word; scans walk the memory one entry per cycle,
  // processing each read word in the cycle after its address went out.
  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    val_nxt    = val_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    pidx_nxt   = pidx_r;
    pend_nxt   = pend_r;
    k_nxt      = k_r;
    acc_nxt    = acc_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    data_nxt   = data_r;
    we         = 1'b0;
    waddr      = '0;
    wdata      = val_r;
    raddr      = '0;
    rd_issue   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_cmd;
          val_nxt    = in_value;
          status_nxt = STAT_OK;
          data_nxt   = '0;
          idx_nxt    = '0;
          pend_nxt   = 1'b0;
          k_nxt      = '0;
          found_nxt  = 1'b0;
          state_nxt  = S_DONE;
          case (in_cmd)
            CMD_APPEND: begin
              if (full) begin
                status_nxt = STAT_FULL;
              end else begin
                we      = 1'b1;
                waddr   = cnt_r[ADDR_W-1:0];
                wdata   = in_value;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            CMD_INSERT: begin
              if (full) begin
                status_nxt = STAT_FULL;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            CMD_RMODD, CMD_MIN: begin
              if (cnt_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            CMD_READ: begin
              if ((POS_W + 1)'(in_position) >= (POS_W + 1)'(CAPACITY)) begin
                status_nxt = STAT_BEYOND;
              end else if ((POS_W + 1)'(in_position) >= (POS_W + 1)'(cnt_r)) begin
                status_nxt = STAT_UNFILLED;
              end else begin
                raddr     = in_position[ADDR_W-1:0];
                state_nxt = S_RDWAIT;
              end
            end
            CMD_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue the next read while entries remain.
        rd_issue = (idx_r < cnt_r);
        if (rd_issue) begin
          raddr   = idx_r[ADDR_W-1:0];
          idx_nxt = idx_r + 1'b1;
        end
        pend_nxt = rd_issue;
        pidx_nxt = idx_r[ADDR_W-1:0];

        if (pend_r) begin
          // Process the word read last cycle. Writes only go to addresses
          // at or below it, never to the one being read now.
          case (cmd_r)
            CMD_MIN: begin
              if ((pidx_r == '0) || (rdata_r < acc_r)) begin
                acc_nxt = rdata_r;
              end
            end
            CMD_RMODD: begin
              if (!rdata_r[0]) begin
                we    = 1'b1;
                waddr = k_r[ADDR_W-1:0];
                wdata = rdata_r;
                k_nxt = k_r + 1'b1;
              end
            end
            CMD_INSERT: begin
              // From the first entry not less than the new word on, each
              // entry is replaced by the carried word and becomes the carry.
              if (found_r || !(rdata_r < val_r)) begin
                we        = 1'b1;
                waddr     = pidx_r;
                wdata     = found_r ? acc_r : val_r;
                acc_nxt   = rdata_r;
                found_nxt = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end else if (!rd_issue) begin
          // All entries seen: wrap up the command.
          state_nxt = S_DONE;
          case (cmd_r)
            CMD_MIN: begin
              data_nxt = acc_r;
            end
            CMD_RMODD: begin
              cnt_nxt = k_r;
            end
            CMD_INSERT: begin
              we      = 1'b1;
              waddr   = cnt_r[ADDR_W-1:0];
              wdata   = found_r ? acc_r : val_r;
              cnt_nxt = cnt_r + 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      S_RDWAIT: begin
        data_nxt  = rdata_r;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    val_r    <= val_nxt;
    idx_r    <= idx_nxt;
    pidx_r   <= pidx_nxt;
    k_r      <= k_nxt;
    acc_r    <= acc_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
    data_r   <= data_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/core/bale_obuf.sv
`default_nettype none

module bale_obuf (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               res_valid,
  output logic                                    res_ready,
  input  wire bale_pkg::result_t                  res,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [bale_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic [bale_pkg::STAT_W-1:0]             out_tuser
);
  import bale_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r, res_nxt;

  // The register takes a new word when empty or when its word leaves now.
  assign res_ready = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (res_valid && res_ready) begin
      valid_nxt = 1'b1;
      res_nxt   = res;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // Pack the output word: data, count, full flag, then zero fill.
  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.status;
  assign out_tdata  = {(OUT_TDATA_W - WORD_W - CNT_W - 1)'(0), res_r.is_full,
                       res_r.count, res_r.data};

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bale_pkg::*;

  // Command codes that the block treats as no operation.
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  localparam int FILL_W      = IN_TDATA_W - WORD_W - POS_W;
  localparam int DRAIN_LIMIT = 20000;
  localparam int SETTLE      = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [CMD_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STAT_W-1:0] out_tuser;

  // Random idling on both sides; cleared for a long quiet stretch.
  bit gaps_on = 1'b1;
  int mismatch_count = 0;

  // Shadow copy of the list and the results it predicts, oldest first.
  word_t list_mem [CAPACITY];
  int list_len = 0;
  result_t pending_results [$];

  bounded_array_list_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one command to the shadow list and returns the result it should give.
  function automatic result_t apply_command(logic [CMD_W-1:0] cmd, word_t value,
                                            logic [POS_W-1:0] pos);
    result_t r;
    int idx;
    int kept;
    r.status = STAT_OK;
    r.data   = '0;
    case (cmd)
      CMD_APPEND: begin
        if (list_len >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          list_mem[list_len] = value;
          list_len++;
        end
      end
      CMD_INSERT: begin
        if (list_len >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          // The word lands before the first entry that is not less than it.
          idx = 0;
          while (idx < list_len && list_mem[idx] < value) idx++;
          for (int k = list_len; k > idx; k--) list_mem[k] = list_mem[k-1];
          list_mem[idx] = value;
          list_len++;
        end
      end
      CMD_RMODD: begin
        if (list_len == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          kept = 0;
          for (int i = 0; i < list_len; i++) begin
            if (!list_mem[i][0]) begin
              list_mem[kept] = list_mem[i];
              kept++;
            end
          end
          list_len = kept;
        end
      end
      CMD_MIN: begin
        if (list_len == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.data = list_mem[0];
          for (int i = 1; i < list_len; i++) begin
            if (list_mem[i] < r.data) r.data = list_mem[i];
          end
        end
      end
      CMD_READ: begin
        if (pos >= CAPACITY) r.status = STAT_BEYOND;
        else if (pos >= list_len) r.status = STAT_UNFILLED;
        else r.data = list_mem[pos];
      end
      CMD_CLEAR: begin
        list_len = 0;
      end
      default: begin
      end
    endcase
    r.count   = CNT_W'(list_len);
    r.is_full = (list_len == CAPACITY);
    return r;
  endfunction

  // Result side: random back-pressure while gaps are enabled.
  always @(posedge clk) begin
    out_tready <= !gaps_on || ($urandom_range(99) >= 20);
  end

  // Every accepted result word is matched against the oldest prediction.
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, status %0d data %0d count %0d full %0b",
                 $time, out_tuser, $signed(out_tdata[WORD_W-1:0]),
                 out_tdata[WORD_W +: CNT_W], out_tdata[WORD_W+CNT_W]);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, out_tuser);
          mismatch_count++;
        end
        if (out_tdata[WORD_W-1:0] !== want.data) begin
          $display("%0t: data expected %0d, got %0d", $time, want.data,
                   $signed(out_tdata[WORD_W-1:0]));
          mismatch_count++;
        end
        if (out_tdata[WORD_W +: CNT_W] !== want.count) begin
          $display("%0t: count expected %0d, got %0d", $time, want.count,
                   out_tdata[WORD_W +: CNT_W]);
          mismatch_count++;
        end
        if (out_tdata[WORD_W+CNT_W] !== want.is_full) begin
          $display("%0t: full flag expected %0b, got %0b", $time, want.is_full,
                   out_tdata[WORD_W+CNT_W]);
          mismatch_count++;
        end
      end
    end
  end

  // Offers one command word, possibly after a random gap, and records its result.
  task automatic send_word(logic [CMD_W-1:0] cmd, word_t value, logic [POS_W-1:0] pos);
    while (gaps_on && $urandom_range(99) < 20) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{FILL_W{1'b0}}, pos, value};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_command(cmd, value, pos));
  endtask

  // Values lean toward the extremes and small numbers so that ties and odd words occur.
  function automatic word_t pick_value();
    case ($urandom_range(9))
      0: return word_t'(32'h8000_0000);
      1: return word_t'(32'h7fff_ffff);
      2: return word_t'($signed($urandom_range(16)) - 8);
      3: return $urandom_range(1) ? word_t'(0) : word_t'(-1);
      default: return word_t'($urandom);
    endcase
  endfunction

  // Positions mostly hit filled entries; the rest cover the whole field.
  function automatic logic [POS_W-1:0] pick_position();
    if (list_len > 0 && $urandom_range(3) != 0) return POS_W'($urandom_range(list_len - 1));
    return POS_W'($urandom_range(63));
  endfunction

  function automatic logic [CMD_W-1:0] pick_command();
    int roll;
    roll = $urandom_range(99);
    if (roll < 22) return CMD_APPEND;
    if (roll < 44) return CMD_INSERT;
    if (roll < 52) return CMD_RMODD;
    if (roll < 64) return CMD_MIN;
    if (roll < 93) return CMD_READ;
    if (roll < 96) return CMD_CLEAR;
    return $urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B;
  endfunction

  // Commands on an empty list, the read bounds and the spare codes.
  task automatic test_empty_list();
    send_word(CMD_MIN, word_t'(0), 6'd0);
    send_word(CMD_RMODD, word_t'(-1), 6'd63);
    send_word(CMD_READ, word_t'(32'h7fff_ffff), 6'd0);
    send_word(CMD_READ, word_t'(0), 6'd32);
    send_word(CMD_READ, word_t'(0), 6'd63);
    send_word(CMD_SPARE_A, word_t'(5), 6'd1);
    send_word(CMD_SPARE_B, word_t'(-5), 6'd2);
  endtask

  // Sorted insert with ties and extremes, then remove-odd with an even head entry followed only by odd ones.
  task automatic test_sorted_order();
    send_word(CMD_INSERT, word_t'(5), 6'd0);
    send_word(CMD_INSERT, word_t'(-3), 6'd0);
    send_word(CMD_INSERT, word_t'(5), 6'd0);
    send_word(CMD_INSERT, word_t'(32'h7fff_ffff), 6'd0);
    send_word(CMD_INSERT, word_t'(32'h8000_0000), 6'd0);
    send_word(CMD_INSERT, word_t'(32'h8000_0001), 6'd0);
    send_word(CMD_APPEND, word_t'(-1), 6'd0);
    send_word(CMD_MIN, word_t'(0), 6'd0);
    send_word(CMD_READ, word_t'(0), 6'd0);
    send_word(CMD_READ, word_t'(0), 6'd6);
    send_word(CMD_READ, word_t'(0), 6'd7);
    send_word(CMD_RMODD, word_t'(0), 6'd0);
    send_word(CMD_READ, word_t'(0), 6'd0);
    send_word(CMD_MIN, word_t'(0), 6'd0);
    send_word(CMD_CLEAR, word_t'(0), 6'd0);
  endtask

  // Random spans of mixed commands; some spans push the list to full and beyond.
  task automatic test_random_traffic(int item_total);
    int sent;
    int span;
    bit fill_span;
    logic [CMD_W-1:0] cmd;
    sent = 0;
    while (sent < item_total) begin
      span      = $urandom_range(15, 60);
      fill_span = ($urandom_range(2) == 0);
      repeat (span) begin
        gaps_on = !(sent >= 200 && sent < 350);
        if (fill_span && (list_len < CAPACITY || $urandom_range(1)))
          cmd = $urandom_range(1) ? CMD_APPEND : CMD_INSERT;
        else
          cmd = pick_command();
        send_word(cmd, pick_value(), pick_position());
        sent++;
      end
    end
    gaps_on = 1'b1;
  endtask

  // Drains outstanding results and gives the verdict.
  task automatic finish_run();
    int waited;
    in_tvalid <= 1'b0;
    waited = 0;
    while (pending_results.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (pending_results.size() > 0)
      $display("%0t: %0d results never arrived", $time, pending_results.size());
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS bounded_array_list_engine");
    end else begin
      $display("FAIL bounded_array_list_engine");
    end
    $finish;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_sorted_order();
    test_random_traffic(600);
    finish_run();
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #5_000_000;
    $display("FAIL bounded_array_list_engine");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/bale_pkg.sv
rtl/core/bale_core.sv
rtl/core/bale_obuf.sv
rtl/core/bounded_array_list_engine.sv
tb/sv/testbench.sv
